// ===== rtl/core/tlc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlc_pkg
// Shared constants and types of the two-level write-back LRU tag cache.
// ----------------------------------------------------------------------------
package tlc_pkg;

    localparam int ADDR_W          = 64;
    localparam int STAMP_W         = 64;
    localparam int OUT_W           = 8;
    localparam int EVICT_W         = 2;

    localparam int DEF_NEAR_SETS   = 64;
    localparam int DEF_FAR_SETS    = 512;
    localparam int DEF_WAY_COUNT   = 8;
    localparam int DEF_LINE_SHIFT  = 6;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK,
        ST_WB_READ,
        ST_WB_LOOK
    } back_state_t;

endpackage

// ===== rtl/core/two_level_writeback_lru_cache_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_level_writeback_lru_cache_unit
// Two-level write-back LRU tag cache: one result per memory request.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                                       | tuser        | tlast
//  s_*     | in  | [63:0] byte_address                         | write_access | last_in_run
//  m_*     | out | [0] first_level_hit [1] second_level_hit    | -            | -
//          |     | [3:2] dirty_evictions [7:4] zero            |              |
//
// Back end: pop, then the look step on a near hit or clean fill, plus the
// write-back read and look steps when a dirty near victim is written back;
// each tag-store step is one read-modify-write of a set row. The result
// register drains before the next pop. Front end: each set index is masked
// from the line when its set count is a power of two, else found bytewise as
// a remainder. After reset both stores are cleared row by row; meanwhile
// requests queue up but are not processed.
// A new item starts only once the previous result has been taken.
module two_level_writeback_lru_cache_unit #(
    parameter int NEAR_SETS  = tlc_pkg::DEF_NEAR_SETS,
    parameter int FAR_SETS   = tlc_pkg::DEF_FAR_SETS,
    parameter int WAY_COUNT  = tlc_pkg::DEF_WAY_COUNT,
    parameter int LINE_SHIFT = tlc_pkg::DEF_LINE_SHIFT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [tlc_pkg::ADDR_W-1:0] s_tdata,   // byte_address
    input  logic                       s_tuser,   // write_access
    input  logic                       s_tlast,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [tlc_pkg::OUT_W-1:0]  m_tdata    // first_level_hit, second_level_hit,
                                                  // dirty_evictions[1:0], zero pad
);

    localparam int LINE_W = tlc_pkg::ADDR_W - LINE_SHIFT;
    localparam int NSW    = NEAR_SETS > 1 ? $clog2(NEAR_SETS) : 1;
    localparam int FSW    = FAR_SETS > 1 ? $clog2(FAR_SETS) : 1;
    localparam int ITEM_W = LINE_W + 2 + NSW + FSW;

    logic              q_full;
    logic              q_valid;
    logic              push;
    logic              pop;
    logic [ITEM_W-1:0] item;
    logic [ITEM_W-1:0] head;

    tlc_front #(
        .NEAR_SETS  (NEAR_SETS),
        .FAR_SETS   (FAR_SETS),
        .LINE_SHIFT (LINE_SHIFT)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .push     (push),
        .item     (item)
    );

    tlc_fifo #(.WIDTH(ITEM_W)) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (item),
        .pop       (pop),
        .full      (q_full),
        .not_empty (q_valid),
        .head      (head)
    );

    tlc_back #(
        .NEAR_SETS  (NEAR_SETS),
        .FAR_SETS   (FAR_SETS),
        .WAY_COUNT  (WAY_COUNT),
        .LINE_SHIFT (LINE_SHIFT)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_head   (head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ===== rtl/core/tlc_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlc_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module tlc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/tlc_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlc_front
// Takes requests, forms the line address and works out both set indexes.
// ----------------------------------------------------------------------------
module tlc_front #(
    parameter int NEAR_SETS  = tlc_pkg::DEF_NEAR_SETS,
    parameter int FAR_SETS   = tlc_pkg::DEF_FAR_SETS,
    parameter int LINE_SHIFT = tlc_pkg::DEF_LINE_SHIFT,
    localparam int LINE_W    = tlc_pkg::ADDR_W - LINE_SHIFT,
    localparam int NSW       = NEAR_SETS > 1 ? $clog2(NEAR_SETS) : 1,
    localparam int FSW       = FAR_SETS > 1 ? $clog2(FAR_SETS) : 1,
    localparam int ITEM_W    = LINE_W + 2 + NSW + FSW
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [tlc_pkg::ADDR_W-1:0] s_tdata,
    input  logic                      s_tuser,
    input  logic                      s_tlast,
    input  logic                      q_full,
    output logic                      push,
    output logic [ITEM_W-1:0]         item
);

    localparam bit NEAR_POW2 = (NEAR_SETS & (NEAR_SETS - 1)) == 0;
    localparam bit FAR_POW2  = (FAR_SETS & (FAR_SETS - 1)) == 0;
    localparam int CHUNK     = 8;
    localparam int NSTEP     = (LINE_W + CHUNK - 1) / CHUNK;
    localparam int SHW       = NSTEP * CHUNK;
    localparam int STEPS     = (NEAR_POW2 && FAR_POW2) ? 0 : NSTEP;
    localparam int CNTW      = $clog2(NSTEP + 1);
    localparam int NVW       = NSW + CHUNK;
    localparam int NMW       = NVW + 2;
    localparam int NPW       = NVW + NMW;
    localparam int FVW       = FSW + CHUNK;
    localparam int FMW       = FVW + 2;
    localparam int FPW       = FVW + FMW;
    // reciprocals for exact division of a (set width + chunk)-bit value
    localparam longint unsigned NRECIP =
        ((64'd1 << (NVW + NSW)) + 64'(NEAR_SETS) - 64'd1) / 64'(NEAR_SETS);
    localparam longint unsigned FRECIP =
        ((64'd1 << (FVW + FSW)) + 64'(FAR_SETS) - 64'd1) / 64'(FAR_SETS);

    logic              hold_valid_reg;
    logic [LINE_W-1:0] line_reg;
    logic [SHW-1:0]    shift_reg;
    logic              wr_reg;
    logic              last_reg;
    logic [NSW-1:0]    nrem_reg;
    logic [FSW-1:0]    frem_reg;
    logic [CNTW-1:0]   cnt_reg;

    logic [CHUNK-1:0]  chunk;
    logic [NVW-1:0]    nv;
    logic [FVW-1:0]    fv;
    logic [NPW-1:0]    nprod;
    logic [FPW-1:0]    fprod;
    logic [CHUNK-1:0]  nq;
    logic [CHUNK-1:0]  fq;
    logic [NSW-1:0]    nrem_next;
    logic [FSW-1:0]    frem_next;
    logic [NSW-1:0]    nset;
    logic [FSW-1:0]    fset;
    logic              accept;

    assign s_tready = !hold_valid_reg;
    assign accept   = s_tvalid && !hold_valid_reg;
    assign push     = hold_valid_reg && (cnt_reg == '0) && !q_full;

    // remainder folded in one byte of the line per cycle, MSB first;
    // quotient digit by reciprocal multiply, then subtract
    always_comb
    begin
        chunk     = shift_reg[SHW-1 -: CHUNK];
        nv        = {nrem_reg, chunk};
        fv        = {frem_reg, chunk};
        nprod     = NPW'(nv) * NPW'(NRECIP);
        fprod     = FPW'(fv) * FPW'(FRECIP);
        nq        = CHUNK'(nprod >> (NVW + NSW));
        fq        = CHUNK'(fprod >> (FVW + FSW));
        nrem_next = NSW'(nv - NVW'(nq * NVW'(NEAR_SETS)));
        frem_next = FSW'(fv - FVW'(fq * FVW'(FAR_SETS)));
    end

    assign nset = NEAR_POW2 ? NSW'(line_reg & LINE_W'(NEAR_SETS - 1)) : nrem_reg;
    assign fset = FAR_POW2  ? FSW'(line_reg & LINE_W'(FAR_SETS - 1))  : frem_reg;
    assign item = {line_reg, wr_reg, last_reg, nset, fset};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            cnt_reg        <= '0;
        end
        else if (accept)
        begin
            hold_valid_reg <= 1'b1;
            cnt_reg        <= CNTW'(STEPS);
        end
        else if (push)
        begin
            hold_valid_reg <= 1'b0;
        end
        else if (hold_valid_reg && cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            line_reg  <= LINE_W'(s_tdata >> LINE_SHIFT);
            shift_reg <= SHW'(s_tdata >> LINE_SHIFT);
            wr_reg    <= s_tuser;
            last_reg  <= s_tlast;
            nrem_reg  <= '0;
            frem_reg  <= '0;
        end
        else if (hold_valid_reg && cnt_reg != '0)
        begin
            shift_reg <= shift_reg << CHUNK;
            nrem_reg  <= nrem_next;
            frem_reg  <= frem_next;
        end
    end

endmodule

// ===== rtl/core/tlc_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlc_fifo
// Two-entry queue between the classifying front and the tag-store back.
// ----------------------------------------------------------------------------
module tlc_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic             full,
    output logic             not_empty,
    output logic [WIDTH-1:0] head
);

    logic [WIDTH-1:0] slot_reg [2];
    logic             wp_reg;
    logic             rp_reg;
    logic [1:0]       count_reg;

    assign full      = count_reg == 2'd2;
    assign not_empty = count_reg != 2'd0;
    assign head      = slot_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg    <= 1'b0;
            rp_reg    <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wp_reg <= !wp_reg;
            if (pop)
                rp_reg <= !rp_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wp_reg] <= push_data;
    end

endmodule

// ===== rtl/core/tlc_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlc_back
// Tag-store sequencer: near lookup, far lookup/fill, dirty write-back.
// ----------------------------------------------------------------------------
module tlc_back #(
    parameter int NEAR_SETS  = tlc_pkg::DEF_NEAR_SETS,
    parameter int FAR_SETS   = tlc_pkg::DEF_FAR_SETS,
    parameter int WAY_COUNT  = tlc_pkg::DEF_WAY_COUNT,
    parameter int LINE_SHIFT = tlc_pkg::DEF_LINE_SHIFT,
    localparam int LINE_W    = tlc_pkg::ADDR_W - LINE_SHIFT,
    localparam int NSW       = NEAR_SETS > 1 ? $clog2(NEAR_SETS) : 1,
    localparam int FSW       = FAR_SETS > 1 ? $clog2(FAR_SETS) : 1,
    localparam int ITEM_W    = LINE_W + 2 + NSW + FSW
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     q_valid,
    input  logic [ITEM_W-1:0]        q_head,
    output logic                     pop,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [tlc_pkg::OUT_W-1:0] m_tdata
);

    localparam int SW   = tlc_pkg::STAMP_W;
    localparam int EW   = tlc_pkg::EVICT_W;
    localparam int WIW  = WAY_COUNT > 1 ? $clog2(WAY_COUNT) : 1;
    localparam int MAXR = NEAR_SETS > FAR_SETS ? NEAR_SETS : FAR_SETS;
    localparam int CLW  = MAXR > 1 ? $clog2(MAXR) : 1;

    typedef struct packed {
        logic [LINE_W-1:0] tag;
        logic [FSW-1:0]    fset;
        logic [SW-1:0]     stamp;
        logic              valid;
        logic              dirty;
    } entry_t;

    typedef entry_t [WAY_COUNT-1:0] row_t;
    localparam int ROW_W = $bits(row_t);

    typedef struct packed {
        logic          hit;
        logic [WIW-1:0] way;
    } find_t;

    function automatic find_t find_way(row_t r, logic [LINE_W-1:0] tag);
        find_t f;
        f.hit = 1'b0;
        f.way = '0;
        for (int w = WAY_COUNT - 1; w >= 0; w--)
        begin
            if (r[w].valid && r[w].tag == tag)
            begin
                f.hit = 1'b1;
                f.way = WIW'(w);
            end
        end
        return f;
    endfunction

    // first invalid way, otherwise lowest stamp with ties to the lower way
    function automatic logic [WIW-1:0] pick_victim(row_t r);
        logic [WIW-1:0] best;
        logic [SW-1:0]  low;
        logic           any_free;
        logic [WIW-1:0] free_way;
        best     = '0;
        low      = r[0].stamp;
        any_free = 1'b0;
        free_way = '0;
        for (int w = 1; w < WAY_COUNT; w++)
        begin
            if (r[w].stamp < low)
            begin
                low  = r[w].stamp;
                best = WIW'(w);
            end
        end
        for (int w = WAY_COUNT - 1; w >= 0; w--)
        begin
            if (!r[w].valid)
            begin
                any_free = 1'b1;
                free_way = WIW'(w);
            end
        end
        return any_free ? free_way : best;
    endfunction

    tlc_pkg::back_state_t state_reg, state_next;

    logic [CLW-1:0]    clr_cnt_reg;
    logic [LINE_W-1:0] line_reg;
    logic              wr_reg;
    logic [NSW-1:0]    nset_reg;
    logic [FSW-1:0]    fset_reg;
    logic [SW-1:0]     stamp_reg;
    logic [SW-1:0]     cur_stamp_reg;
    logic [EW-1:0]     ev_reg;
    logic              hit2_reg;
    logic [LINE_W-1:0] old_tag_reg;
    logic [FSW-1:0]    old_fset_reg;
    logic              out_valid_reg;
    logic              out_h1_reg;
    logic              out_h2_reg;
    logic [EW-1:0]     out_ev_reg;

    logic [LINE_W-1:0] head_line;
    logic              head_wr;
    logic              head_last;
    logic [NSW-1:0]    head_nset;
    logic [FSW-1:0]    head_fset;

    logic              near_we;
    logic [NSW-1:0]    near_waddr;
    logic [NSW-1:0]    near_raddr;
    row_t              near_wrow;
    logic [ROW_W-1:0]  near_rdata;
    logic              far_we;
    logic [FSW-1:0]    far_waddr;
    logic [FSW-1:0]    far_raddr;
    row_t              far_wrow;
    logic [ROW_W-1:0]  far_rdata;

    row_t              near_row;
    row_t              far_row;
    find_t             nfind;
    find_t             ffind;
    logic [WIW-1:0]    fvic;
    logic [WIW-1:0]    nvic;
    logic              ev_a;
    logic              finish;
    logic              fin_h1;
    logic              fin_h2;
    logic [EW-1:0]     fin_ev;
    logic              go_wb;

    assign {head_line, head_wr, head_last, head_nset, head_fset} = q_head;
    assign near_row = row_t'(near_rdata);
    assign far_row  = row_t'(far_rdata);

    tlc_ram #(.WIDTH(ROW_W), .DEPTH(NEAR_SETS)) u_near_ram (
        .clk     (clk),
        .wr_en   (near_we),
        .wr_addr (near_waddr),
        .wr_data (ROW_W'(near_wrow)),
        .rd_addr (near_raddr),
        .rd_data (near_rdata)
    );

    tlc_ram #(.WIDTH(ROW_W), .DEPTH(FAR_SETS)) u_far_ram (
        .clk     (clk),
        .wr_en   (far_we),
        .wr_addr (far_waddr),
        .wr_data (ROW_W'(far_wrow)),
        .rd_addr (far_raddr),
        .rd_data (far_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        pop        = 1'b0;
        near_we    = 1'b0;
        near_waddr = nset_reg;
        near_wrow  = near_row;
        far_we     = 1'b0;
        far_waddr  = fset_reg;
        far_wrow   = far_row;
        near_raddr = nset_reg;
        far_raddr  = fset_reg;
        nfind      = find_way(near_row, line_reg);
        ffind      = find_way(far_row, line_reg);
        fvic       = pick_victim(far_row);
        nvic       = pick_victim(near_row);
        ev_a       = 1'b0;
        finish     = 1'b0;
        fin_h1     = 1'b0;
        fin_h2     = 1'b0;
        fin_ev     = '0;
        go_wb      = 1'b0;

        unique case (state_reg)
            tlc_pkg::ST_CLEAR:
            begin
                near_wrow  = '0;
                far_wrow   = '0;
                near_waddr = NSW'(clr_cnt_reg);
                far_waddr  = FSW'(clr_cnt_reg);
                near_we    = {1'b0, clr_cnt_reg} < (CLW+1)'(NEAR_SETS);
                far_we     = {1'b0, clr_cnt_reg} < (CLW+1)'(FAR_SETS);
                if (clr_cnt_reg == CLW'(MAXR - 1))
                    state_next = tlc_pkg::ST_IDLE;
            end
            tlc_pkg::ST_IDLE:
            begin
                near_raddr = head_nset;
                far_raddr  = head_fset;
                if (q_valid && !out_valid_reg)
                begin
                    pop        = 1'b1;
                    state_next = tlc_pkg::ST_LOOK;
                end
            end
            tlc_pkg::ST_LOOK:
            begin
                near_we = 1'b1;
                if (nfind.hit)
                begin
                    near_wrow[nfind.way].stamp = cur_stamp_reg;
                    if (wr_reg)
                        near_wrow[nfind.way].dirty = 1'b1;
                    finish = 1'b1;
                    fin_h1 = 1'b1;
                end
                else
                begin
                    far_we = 1'b1;
                    if (ffind.hit)
                    begin
                        far_wrow[ffind.way].stamp = cur_stamp_reg;
                    end
                    else
                    begin
                        ev_a = far_row[fvic].valid && far_row[fvic].dirty;
                        far_wrow[fvic] = '{tag: line_reg, fset: fset_reg,
                                           stamp: cur_stamp_reg, valid: 1'b1,
                                           dirty: 1'b0};
                    end
                    near_wrow[nvic] = '{tag: line_reg, fset: fset_reg,
                                        stamp: cur_stamp_reg, valid: 1'b1,
                                        dirty: wr_reg};
                    if (near_row[nvic].valid && near_row[nvic].dirty)
                    begin
                        go_wb      = 1'b1;
                        state_next = tlc_pkg::ST_WB_READ;
                    end
                    else
                    begin
                        finish = 1'b1;
                        fin_h2 = ffind.hit;
                        fin_ev = EW'(ev_a);
                    end
                end
            end
            tlc_pkg::ST_WB_READ:
            begin
                // far row was written last cycle; read the victim's set afresh
                far_raddr  = old_fset_reg;
                state_next = tlc_pkg::ST_WB_LOOK;
            end
            tlc_pkg::ST_WB_LOOK:
            begin
                far_we    = 1'b1;
                far_waddr = old_fset_reg;
                ffind     = find_way(far_row, old_tag_reg);
                if (ffind.hit)
                begin
                    far_wrow[ffind.way].dirty = 1'b1;
                end
                else
                begin
                    ev_a = far_row[fvic].valid && far_row[fvic].dirty;
                    far_wrow[fvic] = '{tag: old_tag_reg, fset: old_fset_reg,
                                       stamp: cur_stamp_reg, valid: 1'b1,
                                       dirty: 1'b1};
                end
                finish = 1'b1;
                fin_h2 = hit2_reg;
                fin_ev = ev_reg + EW'(ev_a);
            end
            default:
            begin
                state_next = tlc_pkg::ST_IDLE;
            end
        endcase

        if (finish)
            state_next = tlc_pkg::ST_IDLE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tlc_pkg::ST_CLEAR;
            clr_cnt_reg   <= '0;
            stamp_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == tlc_pkg::ST_CLEAR)
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (pop)
                stamp_reg <= head_last ? '0 : stamp_reg + 1'b1;
            if (finish)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            line_reg      <= head_line;
            wr_reg        <= head_wr;
            nset_reg      <= head_nset;
            fset_reg      <= head_fset;
            cur_stamp_reg <= stamp_reg + 1'b1;
        end
        if (go_wb)
        begin
            old_tag_reg  <= near_row[nvic].tag;
            old_fset_reg <= near_row[nvic].fset;
            ev_reg       <= EW'(ev_a);
            hit2_reg     <= ffind.hit;
        end
        if (finish)
        begin
            out_h1_reg <= fin_h1;
            out_h2_reg <= fin_h2;
            out_ev_reg <= fin_ev;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(tlc_pkg::OUT_W - 2 - EW)'(0), out_ev_reg, out_h2_reg, out_h1_reg};

endmodule

// ===== rtl/core/tlc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlc_checker
// Port-level checks on the result stream of the cache unit.
// ----------------------------------------------------------------------------
module tlc_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      m_tvalid,
    input logic                      m_tready,
    input logic [tlc_pkg::OUT_W-1:0] m_tdata
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped or changed while stalled");

    a_hit_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
        else $error("both levels report a hit");

    a_near_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[0] |-> m_tdata[3:2] == 2'd0)
        else $error("evictions on a first-level hit");

    a_evict_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[3:2] != 2'd3 && m_tdata[7:4] == 4'd0)
        else $error("eviction count or padding out of range");

endmodule

bind two_level_writeback_lru_cache_unit tlc_checker u_tlc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
